// ===== src/assert_macros.svh =====
// Assertion macros for the checker module.
// Needs a clock named clock and a reset named reset in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Next-cycle implication, inactive while reset is high.
`define HGBS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked during reset as well.
`define HGBS_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/hgbs_pkg.sv =====
// Shared constants and helpers for the hemisphere grid bilinear splat.
// No dependencies.
`default_nettype none
package hgbs_pkg;
   localparam int DEFAULT_GRID_MAX  = 128;
   localparam int DEFAULT_FRAC_BITS = 16;
   localparam int POS_W = 23;
   localparam int WGT_W = 32;
   localparam int GS_W  = 8;
   localparam int VAL_W = 48;
   localparam int SCL_W = VAL_W + 1;
   localparam int ACC_W = VAL_W + 3;
   localparam logic [GS_W-1:0] GS_RESET = 8'd128;

   localparam logic signed [ACC_W-1:0] SAT_HI =
      {{(ACC_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

   // clip a wide signed sum into the bin range
   function automatic logic [VAL_W-1:0] sat_val(input logic signed [ACC_W-1:0] v);
      logic [VAL_W-1:0] r;
      if (v > SAT_HI) r = SAT_HI[VAL_W-1:0];
      else if (v < SAT_LO) r = SAT_LO[VAL_W-1:0];
      else r = v[VAL_W-1:0];
      return r;
   endfunction
endpackage
`default_nettype wire

// ===== src/hgbs_bin_ram.sv =====
// Single-port synchronous bin memory with a registered read.
// Depends on nothing but its parameters.
`default_nettype none
module hgbs_bin_ram #(
   parameter int ADDR_W = 15,
   parameter int DATA_W = 48
) (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [DATA_W-1:0] wdata,
   output logic      [DATA_W-1:0] rdata
);
   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rdata_ff;

   assign rdata = rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) mem[addr] <= wdata;
         else rdata_ff <= mem[addr];
      end
   end
endmodule
`default_nettype wire

// ===== src/hgbs_scale.sv =====
// Scaling unit: round(v * c / 2^FRAC_BITS), half away from zero.
// Two registered partial products, combined combinationally. Uses hgbs_pkg.
`default_nettype none
module hgbs_scale
   import hgbs_pkg::*;
#(
   parameter int FRAC_BITS = DEFAULT_FRAC_BITS
) (
   input  wire logic                    clock,
   input  wire logic                    in_en,
   input  wire logic signed [VAL_W-1:0] in_value,
   input  wire logic [FRAC_BITS:0]      in_coef,
   output logic signed [SCL_W-1:0]      out_value
);
   localparam int HALF_W = 24;
   localparam int PW = HALF_W + FRAC_BITS + 1;
   localparam logic [PW:0] HALF_R = (PW+1)'(1) << (FRAC_BITS - 1);

   logic [VAL_W-1:0] mag;
   logic [PW-1:0]    hi_prod_ff, lo_prod_ff;
   logic             neg_ff;
   logic [PW:0]      lo_sum;
   logic [SCL_W-1:0] mag_r;

   assign mag = in_value[VAL_W-1] ? VAL_W'(-in_value) : in_value;

   always_ff @(posedge clock) begin
      if (in_en) begin
         neg_ff     <= in_value[VAL_W-1];
         hi_prod_ff <= PW'(mag[VAL_W-1:HALF_W]) * PW'(in_coef);
         lo_prod_ff <= PW'(mag[HALF_W-1:0]) * PW'(in_coef);
      end
   end

   always_comb begin
      lo_sum = {1'b0, lo_prod_ff} + HALF_R;
      mag_r  = SCL_W'({hi_prod_ff, {(HALF_W-FRAC_BITS){1'b0}}})
             + SCL_W'(lo_sum >> FRAC_BITS);
      out_value = neg_ff ? $signed(-mag_r) : $signed(mag_r);
   end
endmodule
`default_nettype wire

// ===== src/hemisphere_grid_bilinear_splat.sv =====
// Hemisphere grid bilinear splat: two square grids of 48-bit bins, top level.
// Uses hgbs_pkg, hgbs_bin_ram and hgbs_scale.
//
// Each transaction on req names a grid and a Q.FRAC_BITS position. An
// accumulate transaction adds a signed weight, split bilinearly, into the bin
// under the position and its three nearest neighbors (edge neighbors mirror
// across the Lambert seam); a read transaction returns the same blend of the
// four bins on rsp. Both grids share one single-port memory, and each corner
// is a full read-modify-write in the address, read, multiply, round and
// write-back steps. An item is taken in idle, split in the prepare step
// and its four corners follow; a read then waits in a done step until rsp
// is free and loads it there. A new item is taken only back in idle.
// Corners are handled strictly one after another, so corners that land on
// the same bin on small grids each see the previous update. After reset
// a clearing pass zeroes both grids with req_tready low; csr writes are taken
// always. Write grid_size only while idle; it is clamped to 2..GRID_MAX.
`default_nettype none
module hemisphere_grid_bilinear_splat
   import hgbs_pkg::*;
#(
   parameter int GRID_MAX  = DEFAULT_GRID_MAX,
   parameter int FRAC_BITS = DEFAULT_FRAC_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [79:0] req_tdata,   // x_pos[22:0], y_pos[45:23], weight[77:46], zero pad
   input  wire logic [1:0]  req_tuser,   // action[0], hemisphere[1]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // read_value[47:0]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_wdata    // grid_size
);
   localparam int DW  = $clog2(GRID_MAX + 1);
   localparam int CW  = $clog2(GRID_MAX);
   localparam int NW  = DW + 1;
   localparam int IXW = $clog2(GRID_MAX * GRID_MAX);
   localparam int AW  = IXW + 1;
   localparam int CF  = FRAC_BITS + 1;
   localparam int IW  = POS_W - FRAC_BITS;
   localparam logic [FRAC_BITS-1:0] HALF_F = {1'b1, {(FRAC_BITS-1){1'b0}}};
   localparam logic [CF-1:0]        ONE_F  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [2*CF-1:0]      HALF_P = (2*CF)'(HALF_F);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CLEAR = 4'd1;
   localparam logic [3:0] ST_PREP  = 4'd2;
   localparam logic [3:0] ST_ADDR  = 4'd3;
   localparam logic [3:0] ST_READ  = 4'd4;
   localparam logic [3:0] ST_MUL   = 4'd5;
   localparam logic [3:0] ST_SUM   = 4'd6;
   localparam logic [3:0] ST_WB    = 4'd7;
   localparam logic [3:0] ST_DONE  = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [DW-1:0] dim_ff, dim_in;
   logic [AW:0] clr_ff, clr_in;

   // item registers
   logic action_ff, hemi_ff;
   logic [POS_W-1:0] xp_ff, yp_ff;
   logic signed [WGT_W-1:0] wgt_ff;

   // split position
   logic [CW-1:0] a_ff, b_ff, a_in, b_in;
   logic up_x_ff, up_y_ff, up_x_in, up_y_in;
   logic [FRAC_BITS-1:0] mx_ff, my_ff, mx_in, my_in;

   // per-corner registers
   logic [1:0] corner_ff;
   logic [IXW-1:0] addr_ff, addr_in;
   logic [2*CF-1:0] cprod_ff, cprod_in;
   logic [CF-1:0] coef_ff;
   logic signed [SCL_W-1:0] scaled_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic rsp_valid_ff;
   logic [VAL_W-1:0] rsp_data_ff;

   logic ram_en, ram_we;
   logic [AW-1:0] ram_addr;
   logic [VAL_W-1:0] ram_wdata, ram_rdata;
   logic signed [VAL_W-1:0] scale_in;
   logic signed [SCL_W-1:0] scale_out;
   logic signed [ACC_W-1:0] wb_sum;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // clamp grid_size to the supported range
   always_comb begin
      dim_in = dim_ff;
      if (csr_valid) begin
         if (32'(csr_wdata) > GRID_MAX) dim_in = DW'(GRID_MAX);
         else if (csr_wdata < 8'd2) dim_in = DW'(2);
         else dim_in = DW'(csr_wdata);
      end
   end

   // split both positions: clamp, bin, step side, distance from bin center
   always_comb begin
      logic [IW-1:0] ix, iy;
      logic [FRAC_BITS-1:0] fx, fy;
      ix = xp_ff[POS_W-1:FRAC_BITS];
      iy = yp_ff[POS_W-1:FRAC_BITS];
      if (32'(ix) >= 32'(dim_ff)) begin
         a_in = CW'(dim_ff - DW'(1));
         fx   = '1;
      end else begin
         a_in = CW'(ix);
         fx   = xp_ff[FRAC_BITS-1:0];
      end
      if (32'(iy) >= 32'(dim_ff)) begin
         b_in = CW'(dim_ff - DW'(1));
         fy   = '1;
      end else begin
         b_in = CW'(iy);
         fy   = yp_ff[FRAC_BITS-1:0];
      end
      up_x_in = fx[FRAC_BITS-1];
      up_y_in = fy[FRAC_BITS-1];
      mx_in = up_x_in ? fx - HALF_F : HALF_F - fx;
      my_in = up_y_in ? fy - HALF_F : HALF_F - fy;
   end

   // locate the current corner, apply the mirror rule, form address and weight
   always_comb begin
      logic kx, ky, ox, oy;
      logic [NW-1:0] na, nb, dm1, wx, wy, ca, cb;
      logic [CW+DW-1:0] lin;
      logic [CF-1:0] cx, cy;
      kx  = corner_ff[0];
      ky  = corner_ff[1];
      dm1 = NW'(dim_ff) - NW'(1);
      na  = kx ? (up_x_ff ? NW'(a_ff) + NW'(1) : NW'(a_ff) - NW'(1)) : NW'(a_ff);
      nb  = ky ? (up_y_ff ? NW'(b_ff) + NW'(1) : NW'(b_ff) - NW'(1)) : NW'(b_ff);
      ox  = na[NW-1] || (na == NW'(dim_ff));
      oy  = nb[NW-1] || (nb == NW'(dim_ff));
      wx  = na[NW-1] ? dm1 : '0;
      wy  = nb[NW-1] ? dm1 : '0;
      priority if (ox && oy) begin
         ca = wx;
         cb = wy;
      end else if (ox) begin
         ca = wx;
         cb = dm1 - nb;
      end else if (oy) begin
         ca = dm1 - na;
         cb = wy;
      end else begin
         ca = na;
         cb = nb;
      end
      lin = (CW+DW)'(CW'(cb)) * (CW+DW)'(dim_ff) + (CW+DW)'(CW'(ca));
      addr_in = lin[IXW-1:0];
      cx = kx ? {1'b0, mx_ff} : ONE_F - {1'b0, mx_ff};
      cy = ky ? {1'b0, my_ff} : ONE_F - {1'b0, my_ff};
      cprod_in = (2*CF)'(cx) * (2*CF)'(cy);
   end

   assign scale_in = action_ff ? $signed(ram_rdata) : VAL_W'(wgt_ff);
   assign wb_sum = ACC_W'($signed(ram_rdata)) + ACC_W'(scaled_ff);

   // memory port: clearing writes, corner reads, write-backs
   always_comb begin
      ram_en    = 1'b0;
      ram_we    = 1'b0;
      ram_addr  = {hemi_ff, addr_ff};
      ram_wdata = sat_val(wb_sum);
      unique case (state_ff)
         ST_CLEAR: begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = clr_ff[AW-1:0];
            ram_wdata = '0;
         end
         ST_READ: ram_en = 1'b1;
         ST_WB: begin
            ram_en = !action_ff;
            ram_we = !action_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_PREP;
         ST_CLEAR: begin
            clr_in = clr_ff + (AW+1)'(1);
            if (clr_ff[AW-1:0] == '1) state_in = ST_IDLE;
         end
         ST_PREP:  state_in = ST_ADDR;
         ST_ADDR:  state_in = ST_READ;
         ST_READ:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_SUM;
         ST_SUM:   state_in = ST_WB;
         ST_WB: begin
            if (corner_ff != 2'd3) state_in = ST_ADDR;
            else if (action_ff) state_in = ST_DONE;
            else state_in = ST_IDLE;
         end
         ST_DONE:  if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         dim_ff       <= (32'(GS_RESET) > GRID_MAX) ? DW'(GRID_MAX) : DW'(GS_RESET);
         rsp_valid_ff <= 1'b0;
         corner_ff    <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         dim_ff   <= dim_in;
         // drop the result once taken, load a new one from the done step
         if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_PREP) corner_ff <= '0;
         else if (state_ff == ST_WB) corner_ff <= corner_ff + 2'd1;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         action_ff <= req_tuser[0];
         hemi_ff   <= req_tuser[1];
         xp_ff     <= req_tdata[22:0];
         yp_ff     <= req_tdata[45:23];
         wgt_ff    <= $signed(req_tdata[77:46]);
      end
      if (state_ff == ST_PREP) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         up_x_ff <= up_x_in;
         up_y_ff <= up_y_in;
         mx_ff   <= mx_in;
         my_ff   <= my_in;
         acc_ff  <= '0;
      end
      if (state_ff == ST_ADDR) begin
         addr_ff  <= addr_in;
         cprod_ff <= cprod_in;
      end
      if (state_ff == ST_READ) begin
         // round the corner weight, half up
         coef_ff <= CF'((cprod_ff + HALF_P) >> FRAC_BITS);
      end
      if (state_ff == ST_SUM) scaled_ff <= scale_out;
      if (state_ff == ST_WB && action_ff) acc_ff <= acc_ff + ACC_W'(scaled_ff);
      if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready))
         rsp_data_ff <= sat_val(acc_ff);
   end

   hgbs_bin_ram #(
      .ADDR_W(AW),
      .DATA_W(VAL_W)
   ) u_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   hgbs_scale #(
      .FRAC_BITS(FRAC_BITS)
   ) u_scale (
      .clock     (clock),
      .in_en     (state_ff == ST_MUL),
      .in_value  (scale_in),
      .in_coef   (coef_ff),
      .out_value (scale_out)
   );
endmodule
`default_nettype wire

// ===== src/hgbs_checker.sv =====
// Port-level checks for hemisphere_grid_bilinear_splat, bound to the top level.
// Uses assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module hgbs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata
);
   `HGBS_ASSERT_NEXT_ALWAYS(a_clear_after_reset, reset, !req_tready)
   `HGBS_ASSERT_NEXT(a_one_item_at_a_time, req_tvalid && req_tready, !req_tready)
   `HGBS_ASSERT_NEXT(a_no_instant_result, req_tvalid && req_tready, !$rose(rsp_tvalid))
   `HGBS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
endmodule

bind hemisphere_grid_bilinear_splat hgbs_checker u_hgbs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

// ===== sim/hemisphere_grid_bilinear_splat_tb.sv =====
// Self-checking testbench for the hemisphere grid bilinear splat.
// Depends on hgbs_pkg and the hemisphere_grid_bilinear_splat RTL.
// Drives stream transactions, predicts bin contents and checks read blends.
`timescale 1ns / 100ps
`default_nettype none
module hemisphere_grid_bilinear_splat_tb;
   import hgbs_pkg::*;

   localparam int FB    = DEFAULT_FRAC_BITS;
   localparam int GMAX  = DEFAULT_GRID_MAX;
   localparam int DEPTH = GMAX * GMAX;
   localparam longint BIN_HI = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint BIN_LO = -BIN_HI - 1;

   typedef enum bit {ACCUMULATE = 1'b0, READ_BACK = 1'b1} action_type;
   typedef enum bit {SOUTH = 1'b0, NORTH = 1'b1} hemi_type;

   typedef struct {
      action_type  act;
      hemi_type    hemi;
      logic [22:0] x;
      logic [22:0] y;
      logic [31:0] w;
      bit          known;    // expected blend typed in below
      logic [47:0] kval;
   } splat_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;   // x_pos[22:0], y_pos[45:23], weight[77:46], zero pad
   logic [1:0]  req_tuser;   // action[0], hemisphere[1]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;   // read_value[47:0]
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_wdata;   // grid_size

   // model state: both grids and the grid size register
   longint      bin_store [2][DEPTH];
   logic [7:0]  grid_reg;
   logic [47:0] blend_q [$];
   int          fail_count;
   int          rsp_count;
   bit          calm;        // no idling on either side

   hemisphere_grid_bilinear_splat dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop, reported as a failure.
   initial begin
      #2000000;
      $display("hemisphere_grid_bilinear_splat_tb failed");
      $finish;
   end

   function automatic longint clip48(input longint v);
      if (v > BIN_HI) return BIN_HI;
      if (v < BIN_LO) return BIN_LO;
      return v;
   endfunction

   // round(v*c / 2^FB), half away from zero; split the product to stay in 64 bits
   function automatic longint scale_share(input longint v, input longint unsigned c);
      bit                neg;
      longint unsigned   mag, hi, lo, r;
      neg = v < 0;
      mag = neg ? longint'(0) - v : v;
      hi  = mag >> 24;
      lo  = mag & 64'hFF_FFFF;
      r   = ((hi * c) << (24 - FB)) + ((lo * c + (64'd1 << (FB - 1))) >> FB);
      return neg ? -longint'(r) : longint'(r);
   endfunction

   // Clamp a position to the grid and find the bin, the neighbor step and
   // the distance from the bin center.
   function automatic void split_axis(input logic [22:0] pos, input int dim,
                                      output int bin, output int step,
                                      output longint unsigned m);
      longint unsigned p, f;
      p = pos;
      if ((p >> FB) >= dim) p = (longint'(dim) << FB) - 1;
      bin = int'(p >> FB);
      f   = p & ((64'd1 << FB) - 1);
      if (f >= (64'd1 << (FB - 1))) begin
         step = 1;
         m    = f - (64'd1 << (FB - 1));
      end else begin
         step = -1;
         m    = (64'd1 << (FB - 1)) - f;
      end
   endfunction

   function automatic bit off_grid(input int v, input int dim);
      return v < 0 || v > dim - 1;
   endfunction

   // Apply one transaction to the model; returns 1 with the blend for a read.
   function automatic bit splat_predict(input action_type act, input hemi_type hemi,
                                        input logic [22:0] x, input logic [22:0] y,
                                        input logic [31:0] w,
                                        output logic [47:0] blend);
      int              dim, a, b, sx, sy;
      int              ca [4];
      int              cb [4];
      longint unsigned mx, my, c, one;
      longint unsigned cx [4];
      longint unsigned cy [4];
      longint          wt, acc, idx;
      bit              ox, oy;
      dim = grid_reg;
      if (dim < 2) dim = 2;
      if (dim > GMAX) dim = GMAX;
      split_axis(x, dim, a, sx, mx);
      split_axis(y, dim, b, sy, my);
      // corners: own bin, column neighbor, row neighbor, diagonal
      ca[0] = a;      cb[0] = b;
      ca[1] = a + sx; cb[1] = b;
      if (off_grid(ca[1], dim)) begin
         ca[1] -= sx * dim;
         cb[1] = dim - b - 1;
      end
      ca[2] = a; cb[2] = b + sy;
      if (off_grid(cb[2], dim)) begin
         ca[2] = dim - a - 1;
         cb[2] -= sy * dim;
      end
      ca[3] = a + sx; cb[3] = b + sy;
      ox = off_grid(ca[3], dim);
      oy = off_grid(cb[3], dim);
      if (ox && !oy) begin
         ca[3] -= sx * dim;
         cb[3] = dim - cb[3] - 1;
      end else if (!ox && oy) begin
         ca[3] = dim - ca[3] - 1;
         cb[3] -= sy * dim;
      end else if (ox && oy) begin
         ca[3] -= sx * dim;
         cb[3] -= sy * dim;
      end
      one = 64'd1 << FB;
      cx[0] = one - mx; cy[0] = one - my;
      cx[1] = mx;       cy[1] = one - my;
      cx[2] = one - mx; cy[2] = my;
      cx[3] = mx;       cy[3] = my;
      wt  = longint'($signed(w));
      acc = 0;
      // corners in order, so coinciding bins see earlier updates
      for (int k = 0; k < 4; k++) begin
         c   = (cx[k] * cy[k] + (64'd1 << (FB - 1))) >> FB;
         idx = (longint'(cb[k]) * dim + ca[k]) % DEPTH;
         if (act == ACCUMULATE)
            bin_store[hemi][idx] = clip48(bin_store[hemi][idx] + scale_share(wt, c));
         else
            acc += scale_share(bin_store[hemi][idx], c);
      end
      blend = clip48(acc);
      return act == READ_BACK;
   endfunction

   // Offer one transaction, hold it until taken, then predict its result.
   task automatic push_splat(input splat_row_type r);
      logic [47:0] blend;
      if (!calm && $urandom_range(3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, r.w, r.y, r.x};
      req_tuser  <= {r.hemi, r.act};
      do @(posedge clock); while (!req_tready);
      if (splat_predict(r.act, r.hemi, r.x, r.y, r.w, blend))
         blend_q.push_back(r.known ? r.kval : blend);
   endtask

   task automatic write_grid(input logic [7:0] v);
      req_tvalid <= 1'b0;
      csr_valid  <= 1'b1;
      csr_wdata  <= v;
      do @(posedge clock); while (!csr_ready);
      grid_reg  = v;
      csr_valid <= 1'b0;
   endtask

   // Wait out every expected blend plus the tail of a trailing accumulate.
   task automatic settle;
      req_tvalid <= 1'b0;
      while (blend_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [22:0] rand_pos(input int dim);
      logic [15:0] f;
      case ($urandom_range(7))
         0: f = 16'h8000;
         1: f = 16'h0000;
         2: f = 16'hFFFF;
         default: f = $urandom;
      endcase
      case ($urandom_range(9))
         0: return $urandom;                                 // mostly off the grid
         1: return {7'(dim - 1), f};
         2: return {7'($urandom_range(dim, 127)), f};
         default: return {7'($urandom_range(0, dim - 1)), f};
      endcase
   endfunction

   function automatic splat_row_type rand_row;
      splat_row_type r;
      int            dim;
      dim = (grid_reg < 2) ? 2 : (grid_reg > GMAX) ? GMAX : grid_reg;
      r.act   = action_type'($urandom_range(99) < 40);
      r.hemi  = hemi_type'($urandom_range(1));
      r.x     = rand_pos(dim);
      r.y     = rand_pos(dim);
      r.w     = ($urandom_range(3) == 0) ? 32'($signed($urandom_range(0, 2000)) - 1000)
                                         : 32'($urandom);
      r.known = 1'b0;
      r.kval  = '0;
      return r;
   endfunction

   // Receiver: random stalls, one long hold-off to back the block up.
   initial begin
      bit held;
      logic [47:0] want;
      held       = 1'b0;
      rsp_count  = 0;
      rsp_tready = 1'b0;
      forever begin
         if (!held && rsp_count == 60) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (600) @(posedge clock);
         end else if (!calm && $urandom_range(3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         if (rsp_tvalid && rsp_tready && !reset) begin
            rsp_count++;
            if (blend_q.size() == 0) begin
               $display("%0t: unexpected read_value %h", $time, rsp_tdata);
               fail_count++;
            end else begin
               want = blend_q.pop_front();
               if (rsp_tdata !== want) begin
                  $display("%0t: read_value expected %h actual %h", $time, want, rsp_tdata);
                  fail_count++;
               end
            end
         end
      end
   end

   // Stimulus: reset, directed table, then random phases over grid sizes.
   initial begin
      splat_row_type directed [] = '{
         // reads of an empty grid give zero
         '{READ_BACK,  SOUTH, 23'h000000, 23'h000000, 32'h0,        1'b1, 48'h0},
         '{READ_BACK,  NORTH, 23'h7FFFFF, 23'h7FFFFF, 32'hFFFFFFFF, 1'b1, 48'h0},
         // extremes of weight, exact bin centers, clamped positions
         '{ACCUMULATE, SOUTH, 23'h000000, 23'h000000, 32'h7FFFFFFF, 1'b0, 48'h0},
         '{ACCUMULATE, SOUTH, 23'h008000, 23'h008000, 32'h80000000, 1'b0, 48'h0},
         '{ACCUMULATE, NORTH, 23'h7FFFFF, 23'h7FFFFF, 32'h80000000, 1'b0, 48'h0},
         '{ACCUMULATE, NORTH, 23'h7FFFFF, 23'h000000, 32'h12345678, 1'b0, 48'h0},
         '{ACCUMULATE, SOUTH, 23'h018000, 23'h7F0000, 32'h00000000, 1'b0, 48'h0},
         '{ACCUMULATE, NORTH, 23'h3F4000, 23'h2AC000, 32'hFFFF0000, 1'b0, 48'h0},
         '{ACCUMULATE, SOUTH, 23'h7F8000, 23'h000001, 32'h00010000, 1'b0, 48'h0},
         '{READ_BACK,  SOUTH, 23'h000000, 23'h000000, 32'h0,        1'b0, 48'h0},
         '{READ_BACK,  SOUTH, 23'h008000, 23'h008000, 32'h0,        1'b0, 48'h0},
         '{READ_BACK,  NORTH, 23'h7FFFFF, 23'h7FFFFF, 32'h0,        1'b0, 48'h0},
         '{READ_BACK,  NORTH, 23'h000000, 23'h7FFFFF, 32'h0,        1'b0, 48'h0},
         '{READ_BACK,  SOUTH, 23'h7F8000, 23'h000000, 32'h0,        1'b0, 48'h0},
         '{READ_BACK,  NORTH, 23'h3F4000, 23'h2AC000, 32'h0,        1'b0, 48'h0},
         '{READ_BACK,  SOUTH, 23'h7FFFFF, 23'h000001, 32'h0,        1'b0, 48'h0}
      };
      // out of range sizes clamp to 2 and to the maximum
      logic [7:0] sizes [] = '{8'd2, 8'd255, 8'd0, 8'd1, 8'd5, 8'd128, 8'd3};
      fail_count = 0;
      calm       = 1'b0;
      grid_reg   = GS_RESET;
      foreach (bin_store[h, i]) bin_store[h][i] = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_valid  <= 1'b0;
      csr_wdata  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) push_splat(directed[i]);
      settle();

      foreach (sizes[p]) begin
         write_grid(p == sizes.size() - 1 ? 8'($urandom_range(3, 40)) : sizes[p]);
         calm = (p == sizes.size() - 1);
         repeat (215) push_splat(rand_row());
         settle();
      end

      if (fail_count == 0)
         $display("hemisphere_grid_bilinear_splat_tb passed");
      else
         $display("hemisphere_grid_bilinear_splat_tb failed");
      $finish;
   end
endmodule
`default_nettype wire
